// File: rtl/lms_pkg.sv
`default_nettype none

package lms_pkg;

  // stream widths
  localparam int IN_DATA_W  = 24;  // row(4) col(5) pixel(8), padded to bytes
  localparam int OUT_DATA_W = 72;  // module(3) line(3) px0..px7(64), padded

  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 3;      // module, line, step and column-in-module
  localparam int MOD_PIX = 8;      // pixel bytes per module update

  localparam logic [IDX_W-1:0] LINE_MAX  = 3'd7;
  localparam logic [IDX_W-1:0] STEP_LAST = 3'd7;
  localparam logic [IDX_W-1:0] COL_LAST  = 3'd7;
  localparam logic [IDX_W-1:0] MOD_LAST  = 3'd7;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } seq_state_e;

  // read tag, aligned with the registered RAM read data
  typedef struct packed {
    logic             vld;
    logic             inr;   // pixel lies inside the frame
    logic [IDX_W-1:0] step;  // module update within the tick
    logic [IDX_W-1:0] k;     // column within the module
    logic [IDX_W-1:0] line;
  } rd_tag_t;

  // gather / output status back to the sequencer
  typedef struct packed {
    logic gfull;     // gather buffer holds a complete update
    logic out_busy;  // output register holds an update
    logic done;      // last update of the tick moves to the output
  } gather_stat_t;

endpackage

`default_nettype wire

// File: rtl/lms_ram.sv
`default_nettype none

module lms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/lms_seq.sv
`default_nettype none

module lms_seq #(
  parameter int FRAME_ROWS = 16,
  parameter int FRAME_COLS = 32,
  parameter int AW         = 9
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_type_i,
  input  wire logic [lms_pkg::ROW_W-1:0]   in_row_i,
  input  wire logic [lms_pkg::COL_W-1:0]   in_col_i,
  input  wire logic [lms_pkg::PIX_W-1:0]   in_pixel_i,
  output logic                             ram_we_o,
  output logic      [AW-1:0]               ram_waddr_o,
  output logic      [lms_pkg::PIX_W-1:0]   ram_wdata_o,
  output logic      [AW-1:0]               ram_raddr_o,
  output lms_pkg::rd_tag_t                 tag_o,
  input  wire lms_pkg::gather_stat_t       stat_i
);

  import lms_pkg::*;

  localparam int              DEPTH    = FRAME_ROWS * FRAME_COLS;
  localparam int              CW       = AW + 5;
  localparam logic [AW-1:0]   CLR_LAST = AW'(DEPTH - 1);

  seq_state_e       state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic [IDX_W-1:0] line_q, line_d;
  rd_tag_t          tag_q, tag_d;

  logic             accept;
  logic             issue;
  logic             scan_end;
  logic [ROW_W-1:0] rd_row;
  logic [COL_W-1:0] rd_col;
  logic             rd_inr;
  logic             wr_inr;
  logic [CW-1:0]    rd_lin;
  logic [CW-1:0]    wr_lin;

  assign accept   = in_valid_i && in_ready_o;
  // a new module update starts only once both buffers downstream are free
  assign issue    = (state_q == ST_SCAN) &&
                    ((k_q != '0) || (!stat_i.out_busy && !stat_i.gfull));
  assign scan_end = issue && (step_q == STEP_LAST) && (k_q == COL_LAST);

  // upper modules on even steps, lower (row + 8) on odd steps
  assign rd_row = {step_q[0], line_q};
  assign rd_col = {step_q[2:1], k_q};
  assign rd_inr = ({28'd0, rd_row} < FRAME_ROWS) && ({27'd0, rd_col} < FRAME_COLS);
  assign wr_inr = ({28'd0, in_row_i} < FRAME_ROWS) && ({27'd0, in_col_i} < FRAME_COLS);
  assign rd_lin = CW'(rd_row) * CW'(FRAME_COLS) + CW'(rd_col);
  assign wr_lin = CW'(in_row_i) * CW'(FRAME_COLS) + CW'(in_col_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_type_i == REQ_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat_i.done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs and counters
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(wr_lin);
    ram_wdata_o = in_pixel_i;
    ram_raddr_o = rd_inr ? AW'(rd_lin) : '0;
    clr_d       = clr_q;
    step_d      = step_q;
    k_d         = k_q;
    line_d      = line_q;

    tag_d      = '0;
    tag_d.vld  = issue;
    tag_d.inr  = rd_inr;
    tag_d.step = step_q;
    tag_d.k    = k_q;
    tag_d.line = line_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
      end
      ST_IDLE: begin
        ram_we_o = accept && (in_type_i == REQ_WRITE) && wr_inr;
        step_d   = '0;
        k_d      = '0;
      end
      ST_SCAN: begin
        if (issue) begin
          k_d = k_q + IDX_W'(1);
          if (k_q == COL_LAST) begin
            step_d = step_q + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (stat_i.done) begin
          line_d = (line_q == LINE_MAX) ? '0 : line_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
      k_q     <= '0;
      line_q  <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      k_q     <= k_d;
      line_q  <= line_d;
      tag_q   <= tag_d;
    end
  end

  assign tag_o = tag_q;

endmodule

`default_nettype wire

// File: rtl/lms_gather.sv
`default_nettype none

module lms_gather (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire lms_pkg::rd_tag_t                       tag_i,
  input  wire logic [lms_pkg::PIX_W-1:0]              rdata_i,
  input  wire logic                                   out_ready_i,
  output logic                                        out_valid_o,
  output logic [lms_pkg::IDX_W-1:0]                   out_module_o,
  output logic [lms_pkg::IDX_W-1:0]                   out_line_o,
  output logic [lms_pkg::MOD_PIX*lms_pkg::PIX_W-1:0]  out_px_o,
  output logic                                        out_last_o,
  output lms_pkg::gather_stat_t                       stat_o
);

  import lms_pkg::*;

  logic [MOD_PIX-1:0][PIX_W-1:0] gbuf_q;
  logic                          gfull_q;
  logic [IDX_W-1:0]              gstep_q;
  logic [IDX_W-1:0]              gline_q;

  logic                          ov_q;
  logic [MOD_PIX-1:0][PIX_W-1:0] opx_q;
  logic [IDX_W-1:0]              omod_q;
  logic [IDX_W-1:0]              oline_q;
  logic                          olast_q;

  logic                          xfer;
  logic                          cap_last;

  assign xfer     = gfull_q && (!ov_q || out_ready_i);
  assign cap_last = tag_i.vld && (tag_i.k == COL_LAST);

  // payload
  always_ff @(posedge clk_i) begin
    if (tag_i.vld) begin
      gbuf_q[tag_i.k] <= tag_i.inr ? rdata_i : '0;
    end
    if (cap_last) begin
      gstep_q <= tag_i.step;
      gline_q <= tag_i.line;
    end
    if (xfer) begin
      opx_q   <= gbuf_q;
      omod_q  <= {gstep_q[0], gstep_q[2:1]};
      oline_q <= gline_q;
      olast_q <= (gstep_q == STEP_LAST);
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfull_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cap_last) begin
        gfull_q <= 1'b1;
      end else if (xfer) begin
        gfull_q <= 1'b0;
      end
      if (xfer) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_module_o = omod_q;
  assign out_line_o   = oline_q;
  assign out_px_o     = opx_q;
  assign out_last_o   = olast_q;

  assign stat_o = '{
    gfull:    gfull_q,
    out_busy: ov_q,
    done:     xfer && (gstep_q == STEP_LAST)
  };

endmodule

`default_nettype wire

// File: rtl/led_matrix_line_scanner_top.sv
// Channel  | Dir | Signals            | Payload
// ---------+-----+--------------------+-------------------------------------------
// s_axis   | in  | tvalid/tready      | tdata: row, col, pixel; tuser: 0 write, 1 tick
// m_axis   | out | tvalid/tready      | tdata: module, line, px0..px7; tlast on 8th
//
// Pixel write: no result. Refresh tick: 64 reads, back-to-back with no
// output stall, through the single frame RAM read port (one byte per cycle),
// then the registered RAM read, the gather buffer and the output register.
// After reset the frame RAM is zeroed one entry per cycle, all FRAME_ROWS *
// FRAME_COLS entries (512 by default), with s_axis_tready low. An output stall
// holds the read sequencer at the start of the next module update.
`default_nettype none

module led_matrix_line_scanner_top #(
  parameter int FRAME_ROWS = 16,
  parameter int FRAME_COLS = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [3:0] row, [8:4] col, [16:9] pixel, [23:17] zero
  input  wire logic [lms_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [2:0] module_res, [5:3] scan_line, [13:6] px0 ... [69:62] px7, [71:70] zero
  output logic      [lms_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                                  m_axis_tlast
);

  import lms_pkg::*;

  localparam int DEPTH = FRAME_ROWS * FRAME_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [PIX_W-1:0]             ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [PIX_W-1:0]             ram_rdata;
  rd_tag_t                      tag;
  gather_stat_t                 stat;
  logic [IDX_W-1:0]             out_module;
  logic [IDX_W-1:0]             out_line;
  logic [MOD_PIX*PIX_W-1:0]     out_px;

  // address sequencer: pixel writes, clearing pass, tick read schedule
  lms_seq #(
    .FRAME_ROWS (FRAME_ROWS),
    .FRAME_COLS (FRAME_COLS),
    .AW         (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_type_i   (s_axis_tuser),
    .in_row_i    (s_axis_tdata[3:0]),
    .in_col_i    (s_axis_tdata[8:4]),
    .in_pixel_i  (s_axis_tdata[16:9]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .tag_o       (tag),
    .stat_i      (stat)
  );

  // frame buffer
  lms_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // eight-byte gather buffer and output register
  lms_gather u_gather (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag),
    .rdata_i      (ram_rdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_module_o (out_module),
    .out_line_o   (out_line),
    .out_px_o     (out_px),
    .out_last_o   (m_axis_tlast),
    .stat_o       (stat)
  );

  assign m_axis_tdata = {2'b00, out_px, out_line, out_module};

endmodule

`default_nettype wire

// File: rtl/lms_checker.sv
`default_nettype none

module lms_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [lms_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic                            m_axis_tlast
);

  import lms_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // tlast marks module 7 and only module 7
  a_last_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[2:0] == MOD_LAST)))
    else $error("tlast does not match module index");

  // a tick holds off new items until its last update leaves the gather stage
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_TICK) |=> !s_axis_tready)
    else $error("ready right after a tick");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready while a tick is still in progress");

endmodule

bind led_matrix_line_scanner_top lms_checker u_lms_checker (.*);

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps

// One module update as it leaves the scanner.
typedef struct packed {
  logic [lms_pkg::IDX_W-1:0]               module_idx;
  logic [lms_pkg::IDX_W-1:0]               line;
  logic [lms_pkg::MOD_PIX-1:0][lms_pkg::PIX_W-1:0] px;
  logic                                    last;
} scan_update_t;

// Frame buffer and line counter mirror, plus the updates still owed by the DUT.
class refresh_scoreboard;
  localparam int ROWS = 16;
  localparam int COLS = 32;

  logic [lms_pkg::PIX_W-1:0] frame [ROWS][COLS];
  logic [lms_pkg::IDX_W-1:0] scan_line;
  scan_update_t              pending_updates[$];
  int                        mismatches;
  int                        writes_seen;
  int                        ticks_seen;
  int                        updates_seen;

  function new();
    foreach (frame[r, c]) frame[r][c] = '0;
    scan_line    = '0;
    mismatches   = 0;
    writes_seen  = 0;
    ticks_seen   = 0;
    updates_seen = 0;
  endfunction

  // Accepted input item: a pixel write, or a tick that owes eight updates.
  function void note_item(logic req, logic [lms_pkg::IN_DATA_W-1:0] data);
    scan_update_t upd;
    logic [lms_pkg::ROW_W-1:0] frow;
    int i;
    int k;
    if (req == lms_pkg::REQ_WRITE) begin
      // 4-bit row and 5-bit col always land inside a 16x32 frame
      frame[data[3:0]][data[8:4]] = data[16:9];
      writes_seen++;
      return;
    end
    ticks_seen++;
    for (i = 0; i < 8; i++) begin
      // even steps: upper module i/2; odd steps: the lower module under it
      upd.module_idx = i[0] ? 3'(i / 2 + 4) : 3'(i / 2);
      frow           = {i[0], scan_line};
      upd.line       = scan_line;
      for (k = 0; k < lms_pkg::MOD_PIX; k++) upd.px[k] = frame[frow][(i / 2) * 8 + k];
      upd.last       = (i == 7);
      pending_updates.push_back(upd);
    end
    scan_line = (scan_line == lms_pkg::LINE_MAX) ? '0 : scan_line + 3'd1;
  endfunction

  // Accepted output item against the oldest owed update.
  function void check_update(logic [lms_pkg::OUT_DATA_W-1:0] tdata, logic tlast);
    scan_update_t want;
    logic [lms_pkg::PIX_W-1:0] got_px;
    int k;
    updates_seen++;
    if (pending_updates.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected update, module %0d line %0d", $time, tdata[2:0], tdata[5:3]);
      return;
    end
    want = pending_updates.pop_front();
    if (tdata[2:0] !== want.module_idx) begin
      mismatches++;
      $display("%0t: module index expected %0d actual %0d", $time, want.module_idx, tdata[2:0]);
    end
    if (tdata[5:3] !== want.line) begin
      mismatches++;
      $display("%0t: scan line expected %0d actual %0d", $time, want.line, tdata[5:3]);
    end
    for (k = 0; k < lms_pkg::MOD_PIX; k++) begin
      got_px = tdata[6 + 8 * k +: 8];
      if (got_px !== want.px[k]) begin
        mismatches++;
        $display("%0t: module %0d px%0d expected %02h actual %02h", $time, want.module_idx, k,
                 want.px[k], got_px);
      end
    end
    if (tlast !== want.last) begin
      mismatches++;
      $display("%0t: module %0d last expected %0b actual %0b", $time, want.module_idx,
               want.last, tlast);
    end
  endfunction
endclass

module tb;
  localparam int IDLE_MAX     = 18;    // per-item wait drawn by each side
  localparam int RANDOM_ITEMS = 350;
  localparam int CHUNK        = 40;    // items per idle-mode stretch
  // Quiet-cycle limit: the RAM clear after reset is the longest stretch
  // without a handshake; a tick start plus a full output stall is far
  // shorter. Taken several times over.
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 150;   // > one full tick, catches stray updates

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic [lms_pkg::IN_DATA_W-1:0]   s_axis_tdata  = '0;
  logic                            s_axis_tuser  = lms_pkg::REQ_WRITE;
  logic                            m_axis_tready = 1'b0;
  wire                             s_axis_tready;
  wire                             m_axis_tvalid;
  wire  [lms_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  wire                             m_axis_tlast;

  refresh_scoreboard frame_model;

  // idle modes, switched per stretch so that some stretches run flat out
  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;

  int quiet_cycles = 0;

  led_matrix_line_scanner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // [3:0] row, [8:4] col, [16:9] pixel, upper bits zero
  function automatic logic [lms_pkg::IN_DATA_W-1:0] pack_pixel(
      logic [lms_pkg::ROW_W-1:0] row, logic [lms_pkg::COL_W-1:0] col,
      logic [lms_pkg::PIX_W-1:0] pix);
    return {7'd0, pix, col, row};
  endfunction

  // Drives one input item from a falling edge and returns at the falling edge
  // after it was taken. A zero wait keeps tvalid high, so tvalid never gets
  // two assignments in one step.
  task automatic send_item(logic req, logic [lms_pkg::IN_DATA_W-1:0] data);
    int gap;
    gap = send_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_write(logic [3:0] row, logic [4:0] col, logic [7:0] pix);
    send_item(lms_pkg::REQ_WRITE, pack_pixel(row, col, pix));
  endtask

  // row/col/pixel ride along on a tick but must be ignored
  task automatic send_tick();
    send_item(lms_pkg::REQ_TICK, pack_pixel(4'($urandom_range(0, 15)),
                                            5'($urandom_range(0, 31)),
                                            8'($urandom_range(0, 255))));
  endtask

  // Output side: a fresh stall per update, then ready until one is taken.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Single sampling point: inputs are noted before outputs are checked, and
  // the watchdog counts cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) frame_model.note_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) frame_model.check_update(m_axis_tdata, m_axis_tlast);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d updates still owed", $time,
               quiet_cycles, frame_model.pending_updates.size());
      $display("led_matrix_line_scanner_top verification failed");
      $finish;
    end
  end

  initial begin
    logic [3:0] row;
    frame_model = new();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // tick on a freshly cleared frame, ignored fields all ones
    send_item(lms_pkg::REQ_TICK, pack_pixel(4'hF, 5'h1F, 8'hFF));
    // corners and bit patterns; rows 0/15 show at lines 0/7
    send_write(4'd0,  5'd0,  8'hFF);
    send_write(4'd0,  5'd31, 8'hA5);
    send_write(4'd15, 5'd0,  8'h5A);
    send_write(4'd15, 5'd31, 8'hFF);
    send_write(4'd7,  5'd8,  8'h01);
    send_write(4'd8,  5'd23, 8'h80);
    send_write(4'd0,  5'd7,  8'h00);
    send_write(4'd0,  5'd0,  8'h3C);    // overwrite
    // tick with ignored fields zero, then enough ticks to wrap past line 7
    send_item(lms_pkg::REQ_TICK, pack_pixel(4'h0, 5'h00, 8'h00));
    repeat (8) send_tick();

    // --- random ---
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % CHUNK == 0) begin
        send_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_tick();
      end else if ($urandom_range(0, 1) == 0) begin
        // aim at the row pair the next tick will show
        row = {1'($urandom_range(0, 1)), frame_model.scan_line};
        send_write(row, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      end else begin
        send_write(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid <= 1'b0;
    recv_idle_on = 1'b1;

    // drain; the watchdog ends the run if updates never arrive
    while (frame_model.pending_updates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d pixel writes and %0d refresh ticks, %0d module updates checked.",
             frame_model.writes_seen, frame_model.ticks_seen, frame_model.updates_seen);
    $display("Field mismatches: %0d.", frame_model.mismatches);
    if (frame_model.mismatches == 0 && frame_model.pending_updates.size() == 0) begin
      $display("led_matrix_line_scanner_top verification clean");
    end else begin
      $display("led_matrix_line_scanner_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lms_pkg.sv
rtl/lms_ram.sv
rtl/lms_seq.sv
rtl/lms_gather.sv
rtl/led_matrix_line_scanner_top.sv
rtl/lms_checker.sv
test/tb.sv
